[hw/rtl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg - shared types for the delimited field splitter
//
// Register indexes, policy flags, configuration record, result beats and the codes
// carried on the result channel.
// ----------------------------------------------------------------------------
package dfs_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_DELIM_CHARS = 3'd0;
   localparam logic [2:0] REG_DELIM_EN    = 3'd1;
   localparam logic [2:0] REG_TERM_CHARS  = 3'd2;
   localparam logic [2:0] REG_TERM_EN     = 3'd3;
   localparam logic [2:0] REG_MASK_CHARS  = 3'd4;
   localparam logic [2:0] REG_MASK_EN     = 3'd5;
   localparam logic [2:0] REG_REQ_FIELDS  = 3'd6;
   localparam logic [2:0] REG_POLICY      = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Policy flag bits
   localparam int POLICY_ENFORCE = 0;
   localparam int POLICY_DISCARD = 1;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_MISSING   = 2'd2,
      STATUS_DISCARDED = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] delim_chars;
      logic [3:0]  delim_en;
      logic [31:0] term_chars;
      logic [3:0]  term_en;
      logic [31:0] mask_chars;
      logic [3:0]  mask_en;
      logic [7:0]  req_fields;
      logic [1:0]  policy;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic [7:0] field_index;
      status_type status;
      logic       last;
   } result_type;

   // Zero, one or two result beats produced by one input beat
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

[hw/rtl/delimited_field_splitter.sv]
// ----------------------------------------------------------------------------
// delimited_field_splitter - byte stream to delimited records
//
// Splits a character stream into records of delimited fields and tags
// every kept byte with its field number.
// ----------------------------------------------------------------------------
// The block accepts one input beat per clock while the result queue has room.
// Each beat is registered, classified and turned into zero, one or two result
// beats that are written to the result queue, from which rsp_ is driven.
// The result port moves one beat per cycle, so a sustained run of delimiters
// or terminators that each close a record (field end plus record end) drains
// slower than the input; data and ordinary delimiters give one result beat
// each, masked bytes none. A four-entry result queue sets how far the input
// can run ahead of a stalled result port. The user must write configuration
// through the csr_ port only while no beat is in flight; the block does not
// enforce this. Configuration takes effect at once.
module delimited_field_splitter #(
   parameter int FifoDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // stream_end
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [15:8] field_index,
                                    // [17:16] status, [23:18] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last
   // configuration writes
   input  logic                            csr_we,
   input  logic [dfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dfs_pkg::cfg_type    cfg_ff;
   dfs_pkg::push_type   push;
   dfs_pkg::result_type out_beat;
   logic                room;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_chars <= 32'd44;
         cfg_ff.delim_en    <= 4'd1;
         cfg_ff.term_chars  <= 32'd10;
         cfg_ff.term_en     <= 4'd1;
         cfg_ff.mask_chars  <= 32'd13;
         cfg_ff.mask_en     <= 4'd0;
         cfg_ff.req_fields  <= 8'd1;
         cfg_ff.policy      <= 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            dfs_pkg::REG_DELIM_CHARS: cfg_ff.delim_chars <= csr_wdata[31:0];
            dfs_pkg::REG_DELIM_EN:    cfg_ff.delim_en    <= csr_wdata[3:0];
            dfs_pkg::REG_TERM_CHARS:  cfg_ff.term_chars  <= csr_wdata[31:0];
            dfs_pkg::REG_TERM_EN:     cfg_ff.term_en     <= csr_wdata[3:0];
            dfs_pkg::REG_MASK_CHARS:  cfg_ff.mask_chars  <= csr_wdata[31:0];
            dfs_pkg::REG_MASK_EN:     cfg_ff.mask_en     <= csr_wdata[3:0];
            dfs_pkg::REG_REQ_FIELDS:  cfg_ff.req_fields  <= csr_wdata[7:0];
            dfs_pkg::REG_POLICY:      cfg_ff.policy      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   dfs_record_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .room     (room),
      .push     (push)
   );

   dfs_result_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   // Pack the result beat
   assign rsp_tdata = {6'd0, out_beat.status, out_beat.field_index, out_beat.out_byte};
   assign rsp_tuser = out_beat.kind;
   assign rsp_tlast = out_beat.last;

endmodule

[hw/rtl/dfs_classifier.sv]
// ----------------------------------------------------------------------------
// dfs_classifier - character class match
//
// Compares one byte against four packed character slots in parallel and
// reports a hit on any enabled slot.
// ----------------------------------------------------------------------------
module dfs_classifier (
   input  logic [7:0]  in_byte,
   input  logic [31:0] chars,
   input  logic [3:0]  enable,
   output logic        hit
);

   logic [3:0] slot_hit;

   // Compare every slot at once
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         slot_hit[i] = enable[i] && (chars[8*i +: 8] == in_byte);
      end
   end

   assign hit = |slot_hit;

endmodule

[hw/rtl/dfs_result_fifo.sv]
// ----------------------------------------------------------------------------
// dfs_result_fifo - result beat queue
//
// Small flop queue that takes up to two result beats per cycle while it signals
// room and hands one beat per cycle to the result channel while it is ready.
// ----------------------------------------------------------------------------
module dfs_result_fifo #(
   parameter int Depth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  dfs_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output dfs_pkg::result_type out_beat
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   dfs_pkg::result_type mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_beat  = mem_ff[rd_ptr_ff];
   assign room      = (count_ff <= CountW'(Depth - 2));
   assign wr_next   = ptr_inc(wr_ptr_ff);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_next);
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CountW'(push.count) - CountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming beats
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= CountW'(Depth - 2)))
      else $error("result queue written without room");

   a_level: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CountW'(Depth)))
      else $error("result queue level out of range");

endmodule

[hw/rtl/dfs_record_engine.sv]
// ----------------------------------------------------------------------------
// dfs_record_engine - field and record tracking
//
// Registers the incoming beat, classifies it and, in the same cycle, forms
// the result beats and updates the field and record state.
// ----------------------------------------------------------------------------
module dfs_record_engine (
   input  logic              clock,
   input  logic              reset,
   input  dfs_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   input  logic              room,
   output dfs_pkg::push_type push
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       has_data_ff, has_data_in;
   logic [7:0] count_ff, count_in;
   logic       advance;
   logic       term_hit, delim_hit, mask_hit;
   logic [7:0] req_eff;
   logic [7:0] count_inc;
   dfs_pkg::push_type  push_calc;
   dfs_pkg::result_type r0, r1;
   logic [1:0]         n_res;
   logic               clear;

   assign advance  = in_valid_ff && room;
   assign in_ready = !in_valid_ff || room;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         in_byte_ff <= in_byte;
         in_end_ff  <= in_end;
      end
   end

   // Classify the held byte
   dfs_classifier u_term (
      .in_byte (in_byte_ff),
      .chars   (cfg.term_chars),
      .enable  (cfg.term_en),
      .hit     (term_hit)
   );

   dfs_classifier u_delim (
      .in_byte (in_byte_ff),
      .chars   (cfg.delim_chars),
      .enable  (cfg.delim_en),
      .hit     (delim_hit)
   );

   dfs_classifier u_mask (
      .in_byte (in_byte_ff),
      .chars   (cfg.mask_chars),
      .enable  (cfg.mask_en),
      .hit     (mask_hit)
   );

   assign req_eff   = (cfg.req_fields == 8'd0) ? 8'd1 : cfg.req_fields;
   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

   // Form result beats and next record state
   always_comb begin
      r0          = '{dfs_pkg::KIND_DATA, 8'd0, 8'd0, dfs_pkg::STATUS_OK, 1'b0};
      r1          = r0;
      n_res       = 2'd0;
      clear       = 1'b0;
      has_data_in = has_data_ff;
      count_in    = count_ff;
      if (in_end_ff || term_hit) begin
         clear = 1'b1;
         if (count_ff < req_eff) begin
            if (!has_data_ff) begin
               r0.kind        = dfs_pkg::KIND_RECORD_END;
               r0.field_index = count_inc;
               r0.status      = dfs_pkg::STATUS_EMPTY;
               n_res          = 2'd1;
            end else begin
               r0.kind        = dfs_pkg::KIND_FIELD_END;
               r0.field_index = count_inc;
               r1.kind        = dfs_pkg::KIND_RECORD_END;
               r1.field_index = count_inc;
               if (count_inc == req_eff) begin
                  r1.status = dfs_pkg::STATUS_OK;
               end else if (cfg.policy[dfs_pkg::POLICY_ENFORCE]) begin
                  r1.status = dfs_pkg::STATUS_MISSING;
               end else if (cfg.policy[dfs_pkg::POLICY_DISCARD]) begin
                  r1.status = dfs_pkg::STATUS_DISCARDED;
               end else begin
                  r1.status = dfs_pkg::STATUS_OK;
               end
               n_res = 2'd2;
            end
         end else begin
            // count already reached: drop the open field
            r0.kind        = dfs_pkg::KIND_RECORD_END;
            r0.field_index = count_ff;
            n_res          = 2'd1;
         end
      end else if (delim_hit) begin
         if (!has_data_ff) begin
            r0.kind        = dfs_pkg::KIND_RECORD_END;
            r0.field_index = count_inc;
            r0.status      = dfs_pkg::STATUS_EMPTY;
            n_res          = 2'd1;
            clear          = 1'b1;
         end else begin
            r0.kind        = dfs_pkg::KIND_FIELD_END;
            r0.field_index = count_inc;
            if (count_inc >= req_eff) begin
               r1.kind        = dfs_pkg::KIND_RECORD_END;
               r1.field_index = count_inc;
               n_res          = 2'd2;
               clear          = 1'b1;
            end else begin
               n_res       = 2'd1;
               count_in    = count_inc;
               has_data_in = 1'b0;
            end
         end
      end else if (!mask_hit) begin
         r0.kind        = dfs_pkg::KIND_DATA;
         r0.out_byte    = in_byte_ff;
         r0.field_index = count_ff + 8'd1;
         n_res          = 2'd1;
         has_data_in    = 1'b1;
      end
      if (clear) begin
         has_data_in = 1'b0;
         count_in    = 8'd0;
      end
      // Mark the final beat of this input
      if (n_res == 2'd2) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
      push_calc.count = advance ? n_res : 2'd0;
      push_calc.r0    = r0;
      push_calc.r1    = r1;
   end

   assign push = push_calc;

   // Record state
   always_ff @(posedge clock) begin
      if (reset) begin
         has_data_ff <= 1'b0;
         count_ff    <= 8'd0;
      end else if (advance) begin
         has_data_ff <= has_data_in;
         count_ff    <= count_in;
      end
   end

   a_record_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && clear) |=> (count_ff == 8'd0 && !has_data_ff))
      else $error("record end left state behind");

   a_two_beats_shape: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         (push.r0.kind == dfs_pkg::KIND_FIELD_END && !push.r0.last &&
          push.r1.kind == dfs_pkg::KIND_RECORD_END && push.r1.last))
      else $error("two-beat result not a field end followed by record end");

endmodule
